[rtl/core/euler_zxz_rotation_matrix_top_assert.svh]
// ----------------------------------------------------------------------------
// Euler ZXZ rotation matrix - assertion macros
// Shared concurrent assertion forms, clocked on i_clk, disabled in reset.
// ----------------------------------------------------------------------------
`ifndef EULER_ZXZ_ROTATION_MATRIX_TOP_ASSERT_SVH
`define EULER_ZXZ_ROTATION_MATRIX_TOP_ASSERT_SVH

// property holds at every edge out of reset
`define EZRM_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// antecedent this cycle implies consequent next cycle
`define EZRM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/ezrm_pkg.sv]
// ----------------------------------------------------------------------------
// Euler ZXZ rotation matrix - package
// Datapath types, CORDIC constants and the Q30 product helper.
// ----------------------------------------------------------------------------
package ezrm_pkg;

    localparam int LANES        = 3;
    localparam int CORDIC_STEPS = 28;
    localparam int ENTRIES      = 9;

    localparam logic signed [31:0] CORDIC_X0 = 32'sd652032874;

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    // atan(2^-i) in 2^-32 turn
    localparam logic signed [31:0] ATAN_TURN [0:CORDIC_STEPS-1] = '{
        32'sd536870912, 32'sd316933406, 32'sd167458907, 32'sd85004756,
        32'sd42667331,  32'sd21354465,  32'sd10679838,  32'sd5340245,
        32'sd2670163,   32'sd1335087,   32'sd667544,    32'sd333772,
        32'sd166886,    32'sd83443,     32'sd41722,     32'sd20861,
        32'sd10430,     32'sd5215,      32'sd2608,      32'sd1304,
        32'sd652,       32'sd326,       32'sd163,       32'sd81,
        32'sd41,        32'sd20,        32'sd10,        32'sd5
    };

    typedef struct packed {
        logic [1:0]         q;
        logic signed [31:0] x;
        logic signed [31:0] y;
        logic signed [31:0] z;
    } t_lane;

    typedef t_lane [LANES-1:0] t_lane_vec;

    typedef struct packed {
        logic signed [31:0] c;
        logic signed [31:0] s;
    } t_cs;

    typedef t_cs [LANES-1:0] t_cs_vec;

    // Q30 x Q30 -> Q30, round half up
    function automatic logic signed [31:0] qmul(input logic signed [31:0] a,
                                                input logic signed [31:0] b);
        logic signed [63:0] p;
        p = 64'(a) * 64'(b);
        p = (p + 64'sd536870912) >>> 30;
        return p[31:0];
    endfunction

endpackage

[rtl/core/euler_zxz_rotation_matrix_top.sv]
// ----------------------------------------------------------------------------
// Euler ZXZ rotation matrix - top level
// Bunge angles (phi1 about Z, Phi about X, phi2 about Z) to a 3x3 matrix.
// ----------------------------------------------------------------------------
// Each request carries three binary angles (2^ANGLE_BITS is one turn) and
// returns the nine row-wise matrix entries in signed Q1.(ENTRY_BITS-1),
// with +1.0 saturated to the largest positive code. The block takes one
// request per cycle while the pipeline enable is high; the pipeline is 28 CORDIC
// steps (one per stage, three angles side by side), one quadrant fold, two
// multiplier stages, one sum stage and the round/saturate output register.
// The pipeline moves as a whole on one enable, which is high whenever the
// output register is empty or being taken.
module euler_zxz_rotation_matrix_top #(
    parameter int ANGLE_BITS = 16,
    parameter int ENTRY_BITS = 16
) (
    input  logic                                         i_clk,
    input  logic                                         i_rst_n,
    input  logic                                         i_s_axis_tvalid,
    output logic                                         o_s_axis_tready,
    // first_angle, middle_angle, last_angle, zero pad
    input  logic [((3*ANGLE_BITS+7)/8)*8-1:0]            i_s_axis_tdata,
    output logic                                         o_m_axis_tvalid,
    input  logic                                         i_m_axis_tready,
    // r11, r12, r13, r21, r22, r23, r31, r32, r33, zero pad
    output logic [((9*ENTRY_BITS+7)/8)*8-1:0]            o_m_axis_tdata
);
    import ezrm_pkg::*;

    localparam int OUT_W = ((ENTRIES*ENTRY_BITS+7)/8)*8;
    localparam int PAD_W = OUT_W - ENTRIES*ENTRY_BITS;

    logic                            w_en;
    logic [CORDIC_STEPS:0]           w_cv;
    t_lane_vec                       w_lane [CORDIC_STEPS+1];
    logic                            w_qv;
    t_cs_vec                         w_cs;
    logic [ENTRIES*ENTRY_BITS-1:0]   w_entries;

    assign w_en            = !o_m_axis_tvalid || i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign w_cv[0]         = i_s_axis_tvalid;

    always_comb begin
        logic [31:0] a32;
        for (int l = 0; l < LANES; l++) begin
            a32 = 32'(64'(i_s_axis_tdata[l*ANGLE_BITS +: ANGLE_BITS]) << (32 - ANGLE_BITS));
            w_lane[0][l].q = a32[31:30];
            w_lane[0][l].x = CORDIC_X0;
            w_lane[0][l].y = '0;
            w_lane[0][l].z = {2'b00, a32[29:0]};
        end
    end

    for (genvar i = 0; i < CORDIC_STEPS; i++) begin : g_cordic
        ezrm_cordic_stage #(
            .STEP (i)
        ) u_stage (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_valid (w_cv[i]),
            .i_lane  (w_lane[i]),
            .o_valid (w_cv[i+1]),
            .o_lane  (w_lane[i+1])
        );
    end

    ezrm_quadrant u_quadrant (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (w_cv[CORDIC_STEPS]),
        .i_lane  (w_lane[CORDIC_STEPS]),
        .o_valid (w_qv),
        .o_cs    (w_cs)
    );

    ezrm_matrix #(
        .ENTRY_BITS (ENTRY_BITS)
    ) u_matrix (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_en      (w_en),
        .i_valid   (w_qv),
        .i_cs      (w_cs),
        .o_valid   (o_m_axis_tvalid),
        .o_entries (w_entries)
    );

    if (PAD_W > 0) begin : g_pad
        assign o_m_axis_tdata = {{PAD_W{1'b0}}, w_entries};
    end else begin : g_nopad
        assign o_m_axis_tdata = w_entries;
    end

`include "euler_zxz_rotation_matrix_top_assert.svh"

    `EZRM_ASSERT_ALWAYS(a_valid_rises_on_enable, $rose(o_m_axis_tvalid) |-> $past(w_en), "output valid rose while pipeline stalled")
    `EZRM_ASSERT_NEXT(a_stall_freezes_pipe, !w_en, $stable(w_cv[CORDIC_STEPS:1]), "CORDIC valids moved during stall")
    `EZRM_ASSERT_ALWAYS(a_empty_after_reset, $past(!i_rst_n) |-> !o_m_axis_tvalid, "output valid right after reset")

endmodule

[rtl/core/ezrm_cordic_stage.sv]
// ----------------------------------------------------------------------------
// Euler ZXZ rotation matrix - CORDIC stage
// One registered rotation step for all three angle lanes.
// ----------------------------------------------------------------------------
module ezrm_cordic_stage #(
    parameter int STEP = 0
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  ezrm_pkg::t_lane_vec i_lane,
    output logic                o_valid,
    output ezrm_pkg::t_lane_vec o_lane
);
    import ezrm_pkg::*;

    t_lane_vec n_lane;
    t_lane_vec r_lane;
    logic      r_valid;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            n_lane[l].q = i_lane[l].q;
            if (!i_lane[l].z[31]) begin
                n_lane[l].x = i_lane[l].x - (i_lane[l].y >>> STEP);
                n_lane[l].y = i_lane[l].y + (i_lane[l].x >>> STEP);
                n_lane[l].z = i_lane[l].z - ATAN_TURN[STEP];
            end else begin
                n_lane[l].x = i_lane[l].x + (i_lane[l].y >>> STEP);
                n_lane[l].y = i_lane[l].y - (i_lane[l].x >>> STEP);
                n_lane[l].z = i_lane[l].z + ATAN_TURN[STEP];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_valid = r_valid;
    assign o_lane  = r_lane;

endmodule

[rtl/core/ezrm_quadrant.sv]
// ----------------------------------------------------------------------------
// Euler ZXZ rotation matrix - quadrant fold
// Maps first-quadrant CORDIC results back to the full turn, registered.
// ----------------------------------------------------------------------------
module ezrm_quadrant (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_en,
    input  logic                i_valid,
    input  ezrm_pkg::t_lane_vec i_lane,
    output logic                o_valid,
    output ezrm_pkg::t_cs_vec   o_cs
);
    import ezrm_pkg::*;

    t_cs_vec n_cs;
    t_cs_vec r_cs;
    logic    r_valid;

    always_comb begin
        for (int l = 0; l < LANES; l++) begin
            unique case (i_lane[l].q)
                QUAD_0: begin
                    n_cs[l].c = i_lane[l].x;
                    n_cs[l].s = i_lane[l].y;
                end
                QUAD_1: begin
                    n_cs[l].c = -i_lane[l].y;
                    n_cs[l].s = i_lane[l].x;
                end
                QUAD_2: begin
                    n_cs[l].c = -i_lane[l].x;
                    n_cs[l].s = -i_lane[l].y;
                end
                QUAD_3: begin
                    n_cs[l].c = i_lane[l].y;
                    n_cs[l].s = -i_lane[l].x;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_cs <= n_cs;
        end
    end

    assign o_valid = r_valid;
    assign o_cs    = r_cs;

endmodule

[rtl/core/ezrm_matrix.sv]
// ----------------------------------------------------------------------------
// Euler ZXZ rotation matrix - matrix assembly
// Pairwise products, triple products, row sums, then round and saturate.
// ----------------------------------------------------------------------------
module ezrm_matrix #(
    parameter int ENTRY_BITS = 16
) (
    input  logic                                      i_clk,
    input  logic                                      i_rst_n,
    input  logic                                      i_en,
    input  logic                                      i_valid,
    input  ezrm_pkg::t_cs_vec                         i_cs,
    output logic                                      o_valid,
    output logic [ezrm_pkg::ENTRIES*ENTRY_BITS-1:0]   o_entries
);
    import ezrm_pkg::*;

    localparam int SHR     = (ENTRY_BITS < 31) ? 31 - ENTRY_BITS : 0;
    localparam int RND_POS = (SHR > 0) ? SHR - 1 : 0;
    localparam logic signed [35:0] RND = (SHR > 0) ? (36'sd1 <<< RND_POS) : 36'sd0;
    localparam logic signed [35:0] HI  = (36'sd1 <<< (ENTRY_BITS - 1)) - 36'sd1;
    localparam logic signed [35:0] LO  = -HI - 36'sd1;

    function automatic logic [ENTRY_BITS-1:0] to_entry(input logic signed [33:0] v);
        logic signed [35:0] w;
        w = 36'(v);
        if (ENTRY_BITS >= 32) begin
            w = w <<< 1;
        end else begin
            w = (w + RND) >>> SHR;
        end
        if (w > HI) begin
            return HI[ENTRY_BITS-1:0];
        end else if (w < LO) begin
            return LO[ENTRY_BITS-1:0];
        end
        return w[ENTRY_BITS-1:0];
    endfunction

    logic signed [31:0] c1, s1, c2, s2, c3, s3;
    assign c1 = i_cs[0].c;
    assign s1 = i_cs[0].s;
    assign c2 = i_cs[1].c;
    assign s2 = i_cs[1].s;
    assign c3 = i_cs[2].c;
    assign s3 = i_cs[2].s;

    logic [3:0] r_valid;

    // stage 1: pairwise products
    logic signed [31:0] r1_c1c3, r1_c2s1, r1_c3s1, r1_c1c2, r1_s2s3, r1_c1s3;
    logic signed [31:0] r1_c2c3, r1_s1s3, r1_c3s2, r1_s1s2, r1_c1s2;
    logic signed [31:0] r1_s1, r1_c2, r1_c3, r1_s3;
    // stage 2: triple products
    logic signed [31:0] r2_a11, r2_a12, r2_a21, r2_a22;
    logic signed [31:0] r2_c1c3, r2_c3s1, r2_s2s3, r2_c1s3, r2_s1s3;
    logic signed [31:0] r2_c3s2, r2_s1s2, r2_c1s2, r2_c2;
    // stage 3: sums
    logic signed [33:0] r3_sum [ENTRIES];
    // stage 4: output entries
    logic [ENTRY_BITS-1:0] r4_ent [ENTRIES];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r1_c1c3 <= qmul(c1, c3);
            r1_c2s1 <= qmul(c2, s1);
            r1_c3s1 <= qmul(c3, s1);
            r1_c1c2 <= qmul(c1, c2);
            r1_s2s3 <= qmul(s2, s3);
            r1_c1s3 <= qmul(c1, s3);
            r1_c2c3 <= qmul(c2, c3);
            r1_s1s3 <= qmul(s1, s3);
            r1_c3s2 <= qmul(c3, s2);
            r1_s1s2 <= qmul(s1, s2);
            r1_c1s2 <= qmul(c1, s2);
            r1_s1   <= s1;
            r1_c2   <= c2;
            r1_c3   <= c3;
            r1_s3   <= s3;

            r2_a11  <= qmul(r1_c2s1, r1_s3);
            r2_a12  <= qmul(r1_c1c2, r1_s3);
            r2_a21  <= qmul(r1_c2c3, r1_s1);
            r2_a22  <= qmul(r1_c1c2, r1_c3);
            r2_c1c3 <= r1_c1c3;
            r2_c3s1 <= r1_c3s1;
            r2_s2s3 <= r1_s2s3;
            r2_c1s3 <= r1_c1s3;
            r2_s1s3 <= r1_s1s3;
            r2_c3s2 <= r1_c3s2;
            r2_s1s2 <= r1_s1s2;
            r2_c1s2 <= r1_c1s2;
            r2_c2   <= r1_c2;

            r3_sum[0] <= 34'(r2_c1c3) - 34'(r2_a11);
            r3_sum[1] <= 34'(r2_c3s1) + 34'(r2_a12);
            r3_sum[2] <= 34'(r2_s2s3);
            r3_sum[3] <= -34'(r2_c1s3) - 34'(r2_a21);
            r3_sum[4] <= 34'(r2_a22) - 34'(r2_s1s3);
            r3_sum[5] <= 34'(r2_c3s2);
            r3_sum[6] <= 34'(r2_s1s2);
            r3_sum[7] <= -34'(r2_c1s2);
            r3_sum[8] <= 34'(r2_c2);

            for (int e = 0; e < ENTRIES; e++) begin
                r4_ent[e] <= to_entry(r3_sum[e]);
            end
        end
    end

    always_comb begin
        for (int e = 0; e < ENTRIES; e++) begin
            o_entries[e*ENTRY_BITS +: ENTRY_BITS] = r4_ent[e];
        end
    end

    assign o_valid = r_valid[3];

endmodule
